/* hw/rtl/eip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package eip_pkg;

  // Datagram store geometry
  localparam int DATAGRAM_BYTES = 8192;
  localparam int ADDR_W         = $clog2(DATAGRAM_BYTES);
  localparam int LEN_W          = 14;
  localparam int POS_W          = 16;

  // Frame layout and protocol codes
  localparam logic [6:0]       ETH_HEADER     = 7'd14;
  localparam logic [15:0]      ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]       PROTO_UDP      = 8'h11;
  localparam logic [3:0]       IHL_MIN        = 4'd5;
  localparam logic [6:0]       UDP_HDR_LEN    = 7'd8;
  localparam logic [POS_W-1:0] POS_MAX        = '1;

  // Byte positions of the captured header fields
  localparam logic [POS_W-1:0] POS_ETYPE_HI = 16'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 16'd13;
  localparam logic [POS_W-1:0] POS_VER_IHL  = 16'd14;
  localparam logic [POS_W-1:0] POS_FRAG_HI  = 16'd20;
  localparam logic [POS_W-1:0] POS_FRAG_LO  = 16'd21;
  localparam logic [POS_W-1:0] POS_PROTO    = 16'd23;
  localparam logic [POS_W-1:0] POS_SRC_IP   = 16'd26;
  localparam logic [POS_W-1:0] POS_DST_IP   = 16'd30;

  typedef enum logic [2:0] {
    ST_READY         = 3'd0,
    ST_FRAG_HELD     = 3'd1,
    ST_BAD_ETHERTYPE = 3'd2,
    ST_NOT_UDP       = 3'd3,
    ST_BAD_LENGTH    = 3'd4,
    ST_FRAG_OVERFLOW = 3'd5,
    ST_FRAG_IGNORED  = 3'd6
  } status_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_READ    = 1'b1
  } kind_e;

  typedef enum logic {
    MODE_FRAME = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  // Store write command
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // Result fields ahead of the output register
  typedef struct packed {
    kind_e            kind;
    status_e          status;
    logic [31:0]      src_ip;
    logic [31:0]      dst_ip;
    logic [15:0]      udp_sport;
    logic [15:0]      udp_dport;
    logic [LEN_W-1:0] payload_length;
    logic             rd_hit;
    logic             rd_src;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/eip_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface eip_in_if;
  import eip_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [7:0]        frame_byte;
  logic              frame_end;
  logic [ADDR_W-1:0] read_index;

  modport source (output valid, mode, frame_byte, frame_end, read_index, input ready);
  modport sink   (input valid, mode, frame_byte, frame_end, read_index, output ready);
endinterface

`default_nettype wire

/* hw/rtl/eip_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface eip_out_if;
  import eip_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [2:0]       status;
  logic [31:0]      src_ip;
  logic [31:0]      dst_ip;
  logic [15:0]      udp_sport;
  logic [15:0]      udp_dport;
  logic [LEN_W-1:0] payload_length;
  logic [7:0]       read_byte;

  modport source (output valid, kind, status, src_ip, dst_ip, udp_sport, udp_dport,
                  payload_length, read_byte, input ready);
  modport sink   (input valid, kind, status, src_ip, dst_ip, udp_sport, udp_dport,
                  payload_length, read_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/eip_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module eip_ram #(
  parameter int Depth = 8192,
  parameter int Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/eip_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module eip_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire logic                       mode_i,
  input  wire logic [7:0]                 frame_byte_i,
  input  wire logic                       frame_end_i,
  input  wire logic [eip_pkg::ADDR_W-1:0] read_index_i,
  output logic                            res_valid_o,
  output eip_pkg::result_t                res_o,
  output eip_pkg::mem_wr_t                single_wr_o,
  output eip_pkg::mem_wr_t                reasm_wr_o,
  output logic                            rd_en_o,
  output logic [eip_pkg::ADDR_W-1:0]      rd_addr_o
);
  import eip_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      etype_q, etype_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [7:0]       proto_q, proto_d;
  logic [15:0]      frag_q, frag_d;
  logic [31:0]      sip_q, sip_d, dip_q, dip_d;
  logic [15:0]      sport_q, sport_d, dport_q, dport_d;
  logic [31:0]      fsip_q, fsip_d, fdip_q, fdip_d;
  logic [15:0]      fsport_q, fsport_d, fdport_q, fdport_d;
  logic [POS_W-1:0] fill_q, fill_d;
  logic             rsrc_q, rsrc_d;
  logic [LEN_W-1:0] rlen_q, rlen_d;

  logic             frame_start;
  logic [6:0]       us;
  logic [POS_W-1:0] k;
  logic [POS_W:0]   len, idx_later, sum_off;
  logic [POS_W-1:0] data, offb;
  logic             hok, at_udp, in_store, flow_match, off_match;
  logic [12:0]      off;
  logic             more;
  logic [1:0]       port_sel;

  always_comb begin
    pos_d    = pos_q;
    etype_d  = etype_q;
    ihl_d    = ihl_q;
    proto_d  = proto_q;
    frag_d   = frag_q;
    sip_d    = sip_q;
    dip_d    = dip_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    fsip_d   = fsip_q;
    fdip_d   = fdip_q;
    fsport_d = fsport_q;
    fdport_d = fdport_q;
    fill_d   = fill_q;
    rsrc_d   = rsrc_q;
    rlen_d   = rlen_q;

    res_valid_o = 1'b0;
    res_o       = '0;
    single_wr_o = '0;
    reasm_wr_o  = '0;
    rd_en_o     = 1'b0;
    rd_addr_o   = read_index_i;

    frame_start = (pos_q == '0);
    us = '0; k = '0; len = '0; idx_later = '0; sum_off = '0; data = '0; offb = '0;
    hok = 1'b0; at_udp = 1'b0; in_store = 1'b0; flow_match = 1'b0; off_match = 1'b0;
    off = '0; more = 1'b0; port_sel = '0;

    if (fire_i && mode_i == MODE_READ) begin
      // Issue the store read, the byte joins the registered result in the next cycle
      rd_en_o              = 1'b1;
      res_valid_o          = 1'b1;
      res_o.kind           = KIND_READ;
      res_o.status         = ST_READY;
      res_o.payload_length = rlen_q;
      res_o.rd_hit         = ({1'b0, read_index_i} < rlen_q);
      res_o.rd_src         = rsrc_q;
    end else if (fire_i) begin
      // Clear the capture at frame start
      if (frame_start) begin
        etype_d = '0; ihl_d = '0; proto_d = '0; frag_d = '0;
        sip_d = '0; dip_d = '0; sport_d = '0; dport_d = '0;
        rlen_d = '0;
      end

      // Capture header bytes by position
      if (pos_q == POS_ETYPE_HI) etype_d[15:8] = frame_byte_i;
      if (pos_q == POS_ETYPE_LO) etype_d[7:0]  = frame_byte_i;
      if (pos_q == POS_VER_IHL)  ihl_d         = frame_byte_i[3:0];
      if (pos_q == POS_FRAG_HI)  frag_d[15:8]  = frame_byte_i;
      if (pos_q == POS_FRAG_LO)  frag_d[7:0]   = frame_byte_i;
      if (pos_q == POS_PROTO)    proto_d       = frame_byte_i;
      if (pos_q >= POS_SRC_IP && pos_q < POS_DST_IP) begin
        case (pos_q[1:0])
          2'd2:    sip_d[31:24] = frame_byte_i;
          2'd3:    sip_d[23:16] = frame_byte_i;
          2'd0:    sip_d[15:8]  = frame_byte_i;
          default: sip_d[7:0]   = frame_byte_i;
        endcase
      end
      if (pos_q >= POS_DST_IP && pos_q < POS_DST_IP + 16'd4) begin
        case (pos_q[1:0])
          2'd2:    dip_d[31:24] = frame_byte_i;
          2'd3:    dip_d[23:16] = frame_byte_i;
          2'd0:    dip_d[15:8]  = frame_byte_i;
          default: dip_d[7:0]   = frame_byte_i;
        endcase
      end

      // Locate the UDP header
      us     = ETH_HEADER + {1'b0, ihl_d, 2'b00};
      at_udp = (ihl_d >= IHL_MIN) && (pos_q >= {9'd0, us});
      k      = pos_q - {9'd0, us};
      if (at_udp && k < 16'd4) begin
        port_sel = k[1:0];
        case (port_sel)
          2'd0:    sport_d[15:8] = frame_byte_i;
          2'd1:    sport_d[7:0]  = frame_byte_i;
          2'd2:    dport_d[15:8] = frame_byte_i;
          default: dport_d[7:0]  = frame_byte_i;
        endcase
      end

      hok        = (etype_d == ETHERTYPE_IPV4) && (proto_d == PROTO_UDP) && (ihl_d >= IHL_MIN);
      off        = frag_d[12:0];
      more       = frag_d[13];
      offb       = {off, 3'b000};
      flow_match = (sip_d == fsip_q) && (dip_d == fdip_q);
      off_match  = (offb == fill_q);
      in_store   = (k >= 16'd8) && (k < 16'(DATAGRAM_BYTES + 8));
      idx_later  = {1'b0, fill_q} + {1'b0, k} - 17'd8;

      // Route the payload byte into a store
      if (hok && at_udp) begin
        if (off == '0 && !more) begin
          single_wr_o.en   = in_store;
          single_wr_o.addr = ADDR_W'(k - 16'd8);
          single_wr_o.data = frame_byte_i;
        end else if (off == '0) begin
          if (k == '0) fill_d = '0;
          reasm_wr_o.en   = in_store;
          reasm_wr_o.addr = ADDR_W'(k - 16'd8);
          reasm_wr_o.data = frame_byte_i;
        end else if (flow_match && off_match) begin
          reasm_wr_o.en   = (idx_later < 17'(DATAGRAM_BYTES));
          reasm_wr_o.addr = idx_later[ADDR_W-1:0];
          reasm_wr_o.data = frame_byte_i;
        end
      end

      // Advance the position, saturate on long frames
      pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;

      // Judge the frame on its last byte
      if (frame_end_i) begin
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_VERDICT;
        res_o.src_ip    = sip_d;
        res_o.dst_ip    = dip_d;
        res_o.udp_sport = sport_d;
        res_o.udp_dport = dport_d;
        len     = (pos_q == POS_MAX) ? {1'b0, pos_q} : {1'b0, pos_q} + 17'd1;
        data    = 16'(len - {10'd0, us} - {10'd0, UDP_HDR_LEN});
        sum_off = {1'b0, offb} + {1'b0, data};
        if (etype_d != ETHERTYPE_IPV4) begin
          res_o.status = ST_BAD_ETHERTYPE;
        end else if (proto_d != PROTO_UDP) begin
          res_o.status = ST_NOT_UDP;
        end else if (ihl_d < IHL_MIN) begin
          res_o.status = ST_BAD_LENGTH;
        end else if (len <= {10'd0, us} + {10'd0, UDP_HDR_LEN}) begin
          res_o.status = ST_BAD_LENGTH;
        end else if (data > 16'(DATAGRAM_BYTES)) begin
          res_o.status = ST_BAD_LENGTH;
        end else if (sum_off > 17'(DATAGRAM_BYTES)) begin
          res_o.status = ST_FRAG_OVERFLOW;
        end else if (off == '0 && !more) begin
          rsrc_d               = 1'b0;
          rlen_d               = LEN_W'(data);
          res_o.payload_length = LEN_W'(data);
          res_o.status         = ST_READY;
        end else if (off == '0) begin
          fsip_d       = sip_d;
          fdip_d       = dip_d;
          fsport_d     = sport_d;
          fdport_d     = dport_d;
          fill_d       = data + 16'd8;
          res_o.status = ST_FRAG_HELD;
        end else if (flow_match && off_match) begin
          fill_d = fill_q + data + 16'd8;
          if (more) begin
            res_o.status = ST_FRAG_HELD;
          end else begin
            rsrc_d               = 1'b1;
            rlen_d               = LEN_W'(fill_q + data);
            res_o.payload_length = LEN_W'(fill_q + data);
            res_o.src_ip         = fsip_q;
            res_o.dst_ip         = fdip_q;
            res_o.udp_sport      = fsport_q;
            res_o.udp_dport      = fdport_q;
            res_o.status         = ST_READY;
          end
        end else begin
          res_o.status = ST_FRAG_IGNORED;
        end
        if (res_o.status == ST_BAD_ETHERTYPE || res_o.status == ST_NOT_UDP) begin
          res_o.src_ip    = '0;
          res_o.dst_ip    = '0;
          res_o.udp_sport = '0;
          res_o.udp_dport = '0;
        end
        pos_d = '0;
      end
    end
  end

  // Hold parser and reassembly state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      etype_q  <= '0;
      ihl_q    <= '0;
      proto_q  <= '0;
      frag_q   <= '0;
      sip_q    <= '0;
      dip_q    <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
      fsip_q   <= '0;
      fdip_q   <= '0;
      fsport_q <= '0;
      fdport_q <= '0;
      fill_q   <= '0;
      rsrc_q   <= 1'b0;
      rlen_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      etype_q  <= etype_d;
      ihl_q    <= ihl_d;
      proto_q  <= proto_d;
      frag_q   <= frag_d;
      sip_q    <= sip_d;
      dip_q    <= dip_d;
      sport_q  <= sport_d;
      dport_q  <= dport_d;
      fsip_q   <= fsip_d;
      fdip_q   <= fdip_d;
      fsport_q <= fsport_d;
      fdport_q <= fdport_d;
      fill_q   <= fill_d;
      rsrc_q   <= rsrc_d;
      rlen_q   <= rlen_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/eth_ipv4_udp_parser_reassembler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Role  Contents
// in_i     in   sink  mode, frame_byte, frame_end, read_index
// out_o    out  src   kind, status, src_ip, dst_ip, udp_sport, udp_dport,
//                     payload_length, read_byte
//
// One item per cycle while input is taken: each frame byte does one header capture or one store write.
// A result appears in the cycle after its item, from the output register.
// Reset clears the parser state; the two 8192-byte stores are not cleared.
// Input is taken while the output register is empty or being drained.

module eth_ipv4_udp_parser_reassembler (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  eip_in_if.sink     in_i,
  eip_out_if.source  out_o
);
  import eip_pkg::*;

  logic             fire;
  logic             res_valid;
  result_t          res;
  mem_wr_t          single_wr, reasm_wr;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]       single_rdata, reasm_rdata;

  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  eip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .mode_i      (in_i.mode),
    .frame_byte_i(in_i.frame_byte),
    .frame_end_i (in_i.frame_end),
    .read_index_i(in_i.read_index),
    .res_valid_o (res_valid),
    .res_o       (res),
    .single_wr_o (single_wr),
    .reasm_wr_o  (reasm_wr),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  eip_ram #(.Depth(DATAGRAM_BYTES), .Width(8)) u_single_ram (
    .clk_i  (clk_i),
    .we_i   (single_wr.en),
    .waddr_i(single_wr.addr),
    .wdata_i(single_wr.data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(single_rdata)
  );

  eip_ram #(.Depth(DATAGRAM_BYTES), .Width(8)) u_reasm_ram (
    .clk_i  (clk_i),
    .we_i   (reasm_wr.en),
    .waddr_i(reasm_wr.addr),
    .wdata_i(reasm_wr.data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(reasm_rdata)
  );

  // Load a new result, drop a delivered one
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  // Drive the output item, read data straight from the store
  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_q.kind;
  assign out_o.status         = out_q.status;
  assign out_o.src_ip         = out_q.src_ip;
  assign out_o.dst_ip         = out_q.dst_ip;
  assign out_o.udp_sport      = out_q.udp_sport;
  assign out_o.udp_dport      = out_q.udp_dport;
  assign out_o.payload_length = out_q.payload_length;
  assign out_o.read_byte      = (out_q.kind == KIND_READ && out_q.rd_hit)
                                ? (out_q.rd_src ? reasm_rdata : single_rdata) : 8'd0;

endmodule

`default_nettype wire

/* bench/tb_eth_ipv4_udp_parser_reassembler.sv */
`timescale 1ns / 1ps

module tb_eth_ipv4_udp_parser_reassembler;
  import eip_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1100;

  typedef struct {
    logic        mode;
    logic [7:0]  fbyte;
    logic        fend;
    logic [12:0] idx;
    bit          drain;
  } stim_t;

  typedef struct {
    logic        kind;
    logic [2:0]  status;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [13:0] plen;
    logic [7:0]  rbyte;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  eip_in_if  in_ch ();
  eip_out_if out_ch ();

  eth_ipv4_udp_parser_reassembler u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #5 clk_i = ~clk_i;

  stim_t    pending_q[$];
  verdict_t expected_q[$];
  int       errors = 0;
  int       cycle = 0;
  bit       stim_done = 0;
  bit       in_fire = 0;
  int       items_built = 0;

  // Parser state mirror
  int unsigned pos_cnt = 0;
  logic [15:0] etype = '0, frag = '0;
  logic [7:0]  verihl = '0, proto = '0;
  logic [63:0] faddr = '0, flow = '0;
  logic [31:0] fports = '0, flow_ports = '0;
  int unsigned fill = 0, rlen = 0;
  bit          rsrc = 0;
  logic [7:0]  single_mem[DATAGRAM_BYTES] = '{default: '0};
  logic [7:0]  reasm_mem[DATAGRAM_BYTES] = '{default: '0};

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle);
    errors++;
  endtask

  // Advance the mirror by one item; return a verdict or read result if one is due
  task automatic predict_item(input stim_t it, output bit has, output verdict_t r);
    int unsigned us, k, off, data, offb, idx, plen;
    logic [7:0]  b;
    logic [63:0] addr;
    logic [31:0] ports;
    logic [2:0]  st;
    bit          hok;
    has = 0;
    r = '{default: '0};
    if (it.mode == MODE_READ) begin
      has = 1;
      r.kind = KIND_READ;
      r.plen = rlen[13:0];
      idx = it.idx;
      if (idx < rlen) r.rbyte = rsrc ? reasm_mem[idx] : single_mem[idx];
      return;
    end
    b = it.fbyte;
    if (pos_cnt == 0) begin
      etype = '0; frag = '0; verihl = '0; proto = '0;
      faddr = '0; fports = '0; rlen = 0;
    end
    // header capture
    case (pos_cnt)
      12: etype[15:8] = b[7:0];
      13: etype[7:0] = b[7:0];
      14: verihl = b[7:0];
      20: frag[15:8] = b[7:0];
      21: frag[7:0] = b[7:0];
      23: proto = b[7:0];
      default: begin
        if (pos_cnt >= 26 && pos_cnt <= 29) faddr[32 + 8*(29-pos_cnt) +: 8] = b[7:0];
        else if (pos_cnt >= 30 && pos_cnt <= 33) faddr[8*(33-pos_cnt) +: 8] = b[7:0];
      end
    endcase
    us = 14 + 4 * verihl[3:0];
    if (verihl[3:0] >= 5 && pos_cnt >= us && pos_cnt <= us + 3)
      fports[8*(us+3-pos_cnt) +: 8] = b[7:0];
    // store write
    hok = etype == ETHERTYPE_IPV4 && proto == PROTO_UDP && verihl[3:0] >= 5;
    off = frag[12:0];
    if (hok && pos_cnt >= us) begin
      k = pos_cnt - us;
      if (off == 0 && !frag[13]) begin
        if (k >= 8 && k - 8 < DATAGRAM_BYTES) single_mem[k-8] = b[7:0];
      end else if (off == 0) begin
        if (k == 0) fill = 0;
        if (k >= 8 && k - 8 < DATAGRAM_BYTES) reasm_mem[k-8] = b[7:0];
      end else if (faddr == flow && off * 8 == fill) begin
        idx = fill - 8 + k;
        if (idx < DATAGRAM_BYTES) reasm_mem[idx] = b[7:0];
      end
    end
    if (pos_cnt < 32'hFFFFFF) pos_cnt++;
    if (!it.fend) return;
    // frame verdict
    has = 1;
    plen = 0;
    addr = faddr;
    ports = fports;
    if (etype != ETHERTYPE_IPV4) st = ST_BAD_ETHERTYPE;
    else if (proto != PROTO_UDP) st = ST_NOT_UDP;
    else if (verihl[3:0] < 5) st = ST_BAD_LENGTH;
    else if (pos_cnt <= us + 8) st = ST_BAD_LENGTH;
    else begin
      data = pos_cnt - us - 8;
      offb = off * 8;
      if (data > DATAGRAM_BYTES) st = ST_BAD_LENGTH;
      else if (offb + data > DATAGRAM_BYTES) st = ST_FRAG_OVERFLOW;
      else if (off == 0 && !frag[13]) begin
        rsrc = 0; rlen = data; plen = data; st = ST_READY;
      end else if (off == 0) begin
        flow = faddr; flow_ports = fports; fill = data + 8; st = ST_FRAG_HELD;
      end else if (faddr == flow && offb == fill) begin
        fill += data + 8;
        if (frag[13]) st = ST_FRAG_HELD;
        else begin
          rsrc = 1; rlen = fill - 8; plen = rlen;
          addr = flow; ports = flow_ports; st = ST_READY;
        end
      end else st = ST_FRAG_IGNORED;
    end
    if (st == ST_BAD_ETHERTYPE || st == ST_NOT_UDP) begin
      addr = '0; ports = '0;
    end
    r.kind = KIND_VERDICT;
    r.status = st;
    r.sip = addr[63:32];
    r.dip = addr[31:0];
    r.sport = ports[31:16];
    r.dport = ports[15:0];
    r.plen = plen[13:0];
    pos_cnt = 0;
  endtask

  task automatic push_read(input int hi);
    stim_t it;
    it.mode = MODE_READ;
    it.fbyte = 8'($urandom);
    it.fend = 1'($urandom);
    it.idx = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, hi));
    it.drain = 0;
    pending_q.push_back(it);
    items_built++;
  endtask

  // Queue one frame; after_ip counts bytes beyond the IPv4 header, cut trims the frame
  task automatic push_frame(input logic [15:0] ety, input logic [3:0] ihl,
                            input logic [7:0] prt, input bit more, input logic [12:0] off,
                            input logic [31:0] sip, input logic [31:0] dip,
                            input int after_ip, input int cut);
    logic [7:0] fb[$];
    stim_t it;
    int n, hdr;
    for (int i = 0; i < 12; i++) fb.push_back(8'($urandom));
    fb.push_back(ety[15:8]); fb.push_back(ety[7:0]);
    fb.push_back({4'h4, ihl});
    for (int i = 0; i < 5; i++) fb.push_back(8'($urandom));
    fb.push_back({1'b0, 1'($urandom), more, off[12:8]}); fb.push_back(off[7:0]);
    fb.push_back(8'($urandom)); fb.push_back(prt);
    fb.push_back(8'($urandom)); fb.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) fb.push_back(sip[8*i +: 8]);
    for (int i = 3; i >= 0; i--) fb.push_back(dip[8*i +: 8]);
    hdr = (ihl > 5) ? 4 * (ihl - 5) : 0;
    for (int i = 0; i < hdr + after_ip; i++) fb.push_back(8'($urandom));
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 40) == 0) push_read(64);
      it.mode = MODE_FRAME;
      it.fbyte = fb[i];
      it.fend = (i == n - 1);
      it.idx = 13'($urandom);
      it.drain = 0;
      pending_q.push_back(it);
      items_built++;
    end
  endtask

  function automatic logic [31:0] pick_ip();
    return {24'hC0A800, 6'd0, 2'($urandom)};
  endfunction

  // Fragment chain: first fragment, middle ones, last; optionally broken
  task automatic push_chain(input bit broken);
    logic [31:0] s, d;
    int offw, m, nmid, total;
    s = pick_ip(); d = pick_ip();
    m = $urandom_range(1, 4);
    push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 1, 13'd0, s, d, 8 + 8 * m, 0);
    offw = m + 1;
    total = 8 * m;
    nmid = $urandom_range(0, 2);
    for (int i = 0; i < nmid; i++) begin
      m = $urandom_range(1, 3);
      push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 1, 13'(offw), s, d, 8 * m, 0);
      offw += m;
      total += 8 * m;
    end
    m = $urandom_range(9, 40);
    if (broken && $urandom_range(0, 1))
      push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 0, 13'(offw + 1), s, d, m, 0);
    else if (broken)
      push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 0, 13'(offw), s ^ 32'h1, d, m, 0);
    else
      push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 0, 13'(offw), s, d, m, 0);
    total += m;
    for (int i = $urandom_range(1, 4); i > 0; i--) push_read(total);
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 7))
      0: push_frame(16'($urandom), 4'd5, PROTO_UDP, 0, 0, pick_ip(), pick_ip(), 20, 0);
      1: push_frame(ETHERTYPE_IPV4, 4'd5, 8'($urandom), 0, 0, pick_ip(), pick_ip(), 20, 0);
      2: push_frame(ETHERTYPE_IPV4, 4'($urandom_range(0, 4)), PROTO_UDP, 0, 0,
                    pick_ip(), pick_ip(), 20, 0);
      3: push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 1'($urandom), 13'($urandom),
                    pick_ip(), pick_ip(), 20, $urandom_range(1, 50));
      4: push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 0, 13'd1020, pick_ip(), pick_ip(), 48, 0);
      5: push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 1, 0, pick_ip(), pick_ip(), 24,
                    $urandom_range(20, 40));
      6: push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 1'($urandom), 13'($urandom_range(1, 8)),
                    pick_ip(), pick_ip(), $urandom_range(8, 30), 0);
      default: push_frame(16'($urandom), 4'($urandom), 8'($urandom), 1'($urandom),
                          13'($urandom), 32'($urandom), 32'($urandom),
                          $urandom_range(0, 30), 0);
    endcase
    if ($urandom_range(0, 1)) push_read(32);
  endtask

  // Stimulus plan
  initial begin
    stim_t it;
    bit    drain_set;
    drain_set = 0;
    // directed: one-byte frame, reads with nothing ready, extremes
    push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 0, 0, 32'h0, 32'h0, 0, 1);
    push_read(0);
    push_frame(ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 9, 0);
    push_read(0); push_read(0);
    it = '{mode: MODE_READ, fbyte: 8'hFF, fend: 1'b1, idx: 13'h1FFF, drain: 0};
    pending_q.push_back(it);
    items_built++;
    push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 0, 0, 32'h0, 32'hFFFFFFFF, 8, 0);
    push_frame(ETHERTYPE_IPV4, 4'd4, PROTO_UDP, 0, 0, pick_ip(), pick_ip(), 12, 0);
    push_frame(16'h86DD, 4'd5, PROTO_UDP, 0, 0, pick_ip(), pick_ip(), 4, 0);
    push_frame(ETHERTYPE_IPV4, 4'd5, 8'h06, 0, 0, pick_ip(), pick_ip(), 4, 0);
    push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 0, 13'h1FFF, pick_ip(), pick_ip(), 12, 0);
    push_chain(0);
    // random part
    while (items_built < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          push_frame(ETHERTYPE_IPV4, 4'($urandom_range(5, 7)), PROTO_UDP, 0, 0,
                     pick_ip(), pick_ip(), $urandom_range(9, 40), 0);
          for (int i = $urandom_range(1, 3); i > 0; i--) push_read(40);
        end
        3, 4, 5: push_chain(0);
        6: push_chain(1);
        default: push_noise();
      endcase
      if (!drain_set && pending_q.size() > 500) begin
        pending_q[pending_q.size() - 1].drain = 1;
        drain_set = 1;
      end
    end
  end

  // Reset once
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic bit quiet();
    return cycle >= 600 && cycle < 900;
  endfunction

  // Driver: present items at the falling edge
  stim_t cur;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= MODE_FRAME;
      in_ch.frame_byte <= '0;
      in_ch.frame_end <= 1'b0;
      in_ch.read_index <= '0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        stim_done <= 1;
      end else if (pending_q[0].drain && expected_q.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else if (!quiet() && $urandom_range(0, 99) < 26) begin
        in_ch.valid <= 1'b0;
      end else begin
        cur = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.mode <= cur.mode;
        in_ch.frame_byte <= cur.fbyte;
        in_ch.frame_end <= cur.fend;
        in_ch.read_index <= cur.idx;
      end
    end
  end

  // Receiver: random stalls, one long hold-off
  int holdoff = 0;
  always @(negedge clk_i) begin
    if (cycle == 300) holdoff <= 400;
    else if (holdoff > 0) holdoff <= holdoff - 1;
    if (!rst_ni || holdoff > 0) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet() || ($urandom_range(0, 99) >= 26);
  end

  // Monitor: record accepted items and compare results at the rising edge
  always @(posedge clk_i) begin
    bit       has;
    verdict_t want;
    stim_t    acc;
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_ch.status, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.kind !== want.kind) report_mismatch("kind", out_ch.kind, want.kind);
        if (out_ch.status !== want.status) report_mismatch("status", out_ch.status, want.status);
        if (out_ch.src_ip !== want.sip) report_mismatch("src_ip", out_ch.src_ip, want.sip);
        if (out_ch.dst_ip !== want.dip) report_mismatch("dst_ip", out_ch.dst_ip, want.dip);
        if (out_ch.udp_sport !== want.sport)
          report_mismatch("udp_sport", out_ch.udp_sport, want.sport);
        if (out_ch.udp_dport !== want.dport)
          report_mismatch("udp_dport", out_ch.udp_dport, want.dport);
        if (out_ch.payload_length !== want.plen)
          report_mismatch("payload_length", out_ch.payload_length, want.plen);
        if (out_ch.read_byte !== want.rbyte)
          report_mismatch("read_byte", out_ch.read_byte, want.rbyte);
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      acc.mode = in_ch.mode;
      acc.fbyte = in_ch.frame_byte;
      acc.fend = in_ch.frame_end;
      acc.idx = in_ch.read_index;
      acc.drain = 0;
      predict_item(acc, has, want);
      if (has) expected_q.push_back(want);
    end
  end

  // End of run
  initial begin
    wait (stim_done && expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
